// ===== hw/rtl/sdc_pkg.sv =====
package sdc_pkg;

   // Width of the duplex state.
   localparam int StateBits = 257;
   // 12^4 mod 257: step between successive injection positions.
   localparam int PosStep = 176;
   localparam int DataBits = 32;
   localparam int LenBits = 3;
   localparam int MaxLen = 4;

   typedef logic [StateBits-1:0] state_type;

   typedef enum logic [2:0] {
      OP_ABSORB_UNKEYED = 3'd0,
      OP_ABSORB_KEYED   = 3'd1,
      OP_ENCRYPT        = 3'd2,
      OP_DECRYPT        = 3'd3,
      OP_BLANK          = 3'd4,
      OP_SQUEEZE        = 3'd5,
      OP_INIT           = 3'd6,
      OP_NONE           = 3'd7
   } op_type;

   // One input beat.
   typedef struct packed {
      op_type               op;
      logic [DataBits-1:0]  data_in;
      logic [LenBits-1:0]   length;
   } item_type;

   // One result beat.
   typedef struct packed {
      logic [DataBits-1:0]  data_out;
      logic                 bad_length;
   } result_type;

   // Position 12^(4j) mod 257; only ever called with constant arguments.
   function automatic int sb_pos(input int j);
      int p;
      p = 1;
      for (int k = 0; k < j; k++) begin
         p = (p * PosStep) % StateBits;
      end
      return p;
   endfunction

   // One round: chi, iota, theta, pi.
   function automatic state_type sb_round(input state_type s);
      state_type t;
      state_type u;
      state_type r;
      for (int i = 0; i < StateBits; i++) begin
         t[i] = s[i] ^ (~s[(i + 1) % StateBits] & s[(i + 2) % StateBits]);
      end
      t[0] = ~t[0];
      for (int i = 0; i < StateBits; i++) begin
         u[i] = t[i] ^ t[(i + 3) % StateBits] ^ t[(i + 8) % StateBits];
      end
      for (int i = 0; i < StateBits; i++) begin
         r[i] = u[(12 * i) % StateBits];
      end
      return r;
   endfunction

   // Inject a masked block and the padding bit after 8*len block bits.
   function automatic state_type sb_inject(input state_type s,
                                           input logic [DataBits-1:0] bits,
                                           input logic [LenBits-1:0] len);
      state_type r;
      r = s;
      for (int j = 0; j < DataBits; j++) begin
         r[sb_pos(j)] = r[sb_pos(j)] ^ bits[j];
      end
      case (len)
         3'd0:    r[sb_pos(0)]  = ~r[sb_pos(0)];
         3'd1:    r[sb_pos(8)]  = ~r[sb_pos(8)];
         3'd2:    r[sb_pos(16)] = ~r[sb_pos(16)];
         3'd3:    r[sb_pos(24)] = ~r[sb_pos(24)];
         default: r[sb_pos(32)] = ~r[sb_pos(32)];
      endcase
      return r;
   endfunction

   // Extract: bit j is s[12^(4j)] ^ s[-12^(4j)].
   function automatic logic [DataBits-1:0] sb_extract(input state_type s);
      logic [DataBits-1:0] z;
      for (int j = 0; j < DataBits; j++) begin
         z[j] = s[sb_pos(j)] ^ s[StateBits - sb_pos(j)];
      end
      return z;
   endfunction

endpackage

// ===== hw/rtl/sdc_if.sv =====
interface sdc_req_if
   import sdc_pkg::*;
();
   logic                 valid;
   logic                 ready;
   op_type               op;
   logic [DataBits-1:0]  data_in;
   logic [LenBits-1:0]   length;

   modport source (output valid, output op, output data_in, output length, input ready);
   modport sink   (input valid, input op, input data_in, input length, output ready);
endinterface

interface sdc_rsp_if
   import sdc_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [DataBits-1:0]  data_out;
   logic                 bad_length;

   modport source (output valid, output data_out, output bad_length, input ready);
   modport sink   (input valid, input data_out, input bad_length, output ready);
endinterface

// ===== hw/rtl/sdc_datapath.sv =====
module sdc_datapath
   import sdc_pkg::*;
(
   input  state_type   state,
   input  item_type    item,
   output state_type   state_next,
   output result_type  result
);

   logic [LenBits-1:0]   len_eff;
   logic [DataBits-1:0]  mask;
   logic [DataBits-1:0]  data_m;
   logic [DataBits-1:0]  extract;
   logic [DataBits-1:0]  xored;
   logic [DataBits-1:0]  inj_bits;
   state_type            rnd1;
   state_type            dup_block;
   state_type            dup_empty;
   state_type            dup_twice;

   // Lengths above four saturate, except for unkeyed absorb, which rejects lengths above one.
   always_comb begin
      if (item.length > LenBits'(MaxLen) && item.op != OP_ABSORB_UNKEYED) begin
         len_eff = LenBits'(MaxLen);
      end else begin
         len_eff = item.length;
      end
   end

   // Byte mask of the valid block bytes.
   always_comb begin
      case (len_eff)
         3'd0:    mask = 32'h0000_0000;
         3'd1:    mask = 32'h0000_00ff;
         3'd2:    mask = 32'h0000_ffff;
         3'd3:    mask = 32'h00ff_ffff;
         default: mask = 32'hffff_ffff;
      endcase
   end

   assign data_m  = item.data_in & mask;
   assign extract = sb_extract(state);
   assign xored   = (data_m ^ extract) & mask;

   // Decrypt absorbs the recovered plaintext, everything else the input block.
   assign inj_bits = (item.op == OP_DECRYPT) ? xored : data_m;

   // Duplex calls built on one shared first round.
   assign rnd1      = sb_round(state);
   assign dup_block = sb_inject(rnd1, inj_bits, len_eff);
   assign dup_empty = sb_inject(rnd1, '0, '0);
   assign dup_twice = sb_inject(sb_round(dup_block), '0, '0);

   // Operation decode.
   always_comb begin
      state_next        = state;
      result.data_out   = '0;
      result.bad_length = 1'b0;
      unique case (item.op)
         OP_ABSORB_UNKEYED: begin
            if (item.length > 3'd1) begin
               result.bad_length = 1'b1;
            end else begin
               state_next = dup_twice;
            end
         end
         OP_ABSORB_KEYED: begin
            state_next = dup_block;
         end
         OP_ENCRYPT, OP_DECRYPT: begin
            state_next      = dup_block;
            result.data_out = xored;
         end
         OP_BLANK: begin
            state_next = dup_empty;
         end
         OP_SQUEEZE: begin
            if (len_eff != 3'd0) begin
               state_next      = dup_empty;
               result.data_out = extract & mask;
            end
         end
         OP_INIT: begin
            state_next = '0;
         end
         default: begin
            state_next = state;
         end
      endcase
   end

endmodule

// ===== hw/rtl/sponge_duplex_cipher_257.sv =====
// Channel   Direction  Beat contents
// req_chan  in         op, data_in, length
// rsp_chan  out        data_out, bad_length
//
// Every beat gives exactly one result beat. One beat is taken per cycle while
// the result side does not stall: the input register, the round logic (up to
// two chained rounds) and the result register form a two-stage pipeline, and
// the 257-bit state is updated as a beat moves from the input register to the
// result register. A synchronous reset clears the state and both valid flags.
// When the result register is held, the input register holds too, and the
// request side stops once both are full.
module sponge_duplex_cipher_257
   import sdc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   sdc_req_if.sink        req_chan,
   sdc_rsp_if.source      rsp_chan
);

   logic        in_valid_ff;
   logic        in_valid_in;
   item_type    in_item_ff;
   logic        out_valid_ff;
   logic        out_valid_in;
   result_type  out_res_ff;
   state_type   state_ff;
   state_type   state_in;
   result_type  res_in;
   logic        advance;
   logic        req_take;

   // A beat leaves the input register when the result register is free.
   assign advance  = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_take = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !in_valid_ff || advance;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_chan.ready);

   sdc_datapath u_datapath (
      .state      (state_ff),
      .item       (in_item_ff),
      .state_next (state_in),
      .result     (res_in)
   );

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.op      <= req_chan.op;
         in_item_ff.data_in <= req_chan.data_in;
         in_item_ff.length  <= req_chan.length;
      end
      if (advance) begin
         out_res_ff <= res_in;
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.data_out   = out_res_ff.data_out;
   assign rsp_chan.bad_length = out_res_ff.bad_length;

endmodule

// ===== hw/rtl/sdc_checker.sv =====
module sdc_checker
   import sdc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic [DataBits-1:0]  rsp_data_out,
   input  logic                 rsp_bad_length
);

   // A result beat that is not taken stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped while stalled");

   // The request side only stops when the result side is full and stalled.
   a_ready_low: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request stalled without a held result");

   // A rejected absorb never carries output data.
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_length |-> rsp_data_out == '0)
      else $error("bad length beat with nonzero data");

   // Nothing is offered right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind sponge_duplex_cipher_257 sdc_checker u_sdc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_data_out   (rsp_chan.data_out),
   .rsp_bad_length (rsp_chan.bad_length)
);

// ===== tb/sdc_duplex_checker.sv =====
module sdc_duplex_checker
   import sdc_pkg::*;
(
   input  logic  clock,
   input  logic  reset,
   sdc_req_if    req_mon,
   sdc_rsp_if    rsp_mon,
   output int    mismatches,
   output int    outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   // Shadow copy of the duplex state and the results still owed by the block.
   state_type  sponge;
   result_type due_results[$];
   // Injection and extraction taps: tap[j] = 12^(4j) mod 257, for j = 0..32.
   int         tap [0:32];

   initial begin : tap_table
      int p;
      p = 1;
      for (int j = 0; j <= 32; j++) begin
         tap[j] = p;
         p = (p * PosStep) % StateBits;
      end
   end

   // Cyclic shift so that bit i of the result is bit (i + k) mod 257 of v.
   function automatic state_type rotate_down(input state_type v, input int k);
      return (v >> k) | (v << (StateBits - k));
   endfunction

   // One round of the permutation, built from whole-vector shifts where possible.
   function automatic state_type round_of(input state_type s);
      state_type mixed;
      state_type spread;
      state_type moved;
      mixed = s ^ (~rotate_down(s, 1) & rotate_down(s, 2));
      mixed[0] = mixed[0] ^ 1'b1;
      spread = mixed ^ rotate_down(mixed, 3) ^ rotate_down(mixed, 8);
      for (int i = 0; i < StateBits; i++) begin
         moved[i] = spread[(12 * i) % StateBits];
      end
      return moved;
   endfunction

   // A duplex call: round, then block bits and the padding one at the taps.
   function automatic state_type duplexed(input state_type s, input logic [31:0] blk,
                                          input int nbits);
      state_type r;
      r = round_of(s);
      for (int j = 0; j < nbits; j++) begin
         r[tap[j]] = r[tap[j]] ^ blk[j];
      end
      r[tap[nbits]] = r[tap[nbits]] ^ 1'b1;
      return r;
   endfunction

   function automatic logic [31:0] keystream(input state_type s);
      logic [31:0] z;
      for (int j = 0; j < 32; j++) begin
         z[j] = s[tap[j]] ^ s[StateBits - tap[j]];
      end
      return z;
   endfunction

   function automatic logic [31:0] byte_mask(input int n);
      if (n >= 4) begin
         return '1;
      end
      return (32'd1 << (8 * n)) - 32'd1;
   endfunction

   // Work out the result of one beat and advance the shadow state.
   function automatic result_type process_block(input op_type op, input logic [31:0] din,
                                                input logic [2:0] len_in);
      result_type  r;
      int          n;
      logic [31:0] m;
      logic [31:0] blk;
      n = int'(len_in);
      if (n > MaxLen && op != OP_ABSORB_UNKEYED) begin
         n = MaxLen;
      end
      m = byte_mask(n);
      blk = din & m;
      r = '0;
      case (op)
         OP_ABSORB_UNKEYED: begin
            if (n > 1) begin
               r.bad_length = 1'b1;
            end else begin
               sponge = duplexed(duplexed(sponge, blk, 8 * n), '0, 0);
            end
         end
         OP_ABSORB_KEYED: begin
            sponge = duplexed(sponge, blk, 8 * n);
         end
         OP_ENCRYPT: begin
            r.data_out = (blk ^ keystream(sponge)) & m;
            sponge = duplexed(sponge, blk, 8 * n);
         end
         OP_DECRYPT: begin
            r.data_out = (blk ^ keystream(sponge)) & m;
            sponge = duplexed(sponge, r.data_out, 8 * n);
         end
         OP_BLANK: begin
            sponge = duplexed(sponge, '0, 0);
         end
         OP_SQUEEZE: begin
            // An empty squeeze leaves the state alone.
            if (n != 0) begin
               r.data_out = keystream(sponge) & m;
               sponge = duplexed(sponge, '0, 0);
            end
         end
         OP_INIT: begin
            sponge = '0;
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
      mismatches++;
   endtask

   // Results are compared before the new beat is predicted, so the oldest
   // expectation always meets the oldest result.
   always @(posedge clock) begin : watch
      result_type oldest;
      if (reset) begin
         sponge = '0;
         due_results.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (due_results.size() == 0) begin
               report_mismatch("result beat with nothing pending", rsp_mon.data_out, '0);
            end else begin
               oldest = due_results.pop_front();
               if (rsp_mon.data_out !== oldest.data_out) begin
                  report_mismatch("data_out", rsp_mon.data_out, oldest.data_out);
               end
               if (rsp_mon.bad_length !== oldest.bad_length) begin
                  report_mismatch("bad_length", 32'(rsp_mon.bad_length),
                                  32'(oldest.bad_length));
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            due_results.push_back(process_block(req_mon.op, req_mon.data_in,
                                                req_mon.length));
         end
      end
      outstanding = due_results.size();
   end

endmodule

// ===== tb/testbench.sv =====
module testbench
   import sdc_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CycleLimit = 400000;
   localparam int BeatsPerPhase = 475;

   logic clock;
   logic reset;
   int   idle_pct;
   int   stall_pct;
   int   cycles;
   int   beats_sent;
   int   errors;
   int   outstanding;

   sdc_req_if req_chan();
   sdc_rsp_if rsp_chan();

   sponge_duplex_cipher_257 dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   sdc_duplex_checker duplex_check (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_chan),
      .rsp_mon     (rsp_chan),
      .mismatches  (errors),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // The result side stalls at random in the phases that ask for it.
   always @(negedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= stall_pct);
   end

   // Watchdog.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CycleLimit) begin
         $display("** sponge_duplex_cipher_257: FAILED **");
         $finish;
      end
   end

   // Present one beat, with random idle cycles ahead of it, and hold it until taken.
   task automatic send_beat(input op_type op, input logic [31:0] din,
                            input logic [2:0] len);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.op      <= op;
      req_chan.data_in <= din;
      req_chan.length  <= len;
      @(posedge clock);
      while (!req_chan.ready) begin
         @(posedge clock);
      end
      beats_sent++;
   endtask

   // Stop sending until every expected result has been seen.
   task automatic drain;
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (outstanding != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic noise_beat;
      send_beat(op_type'($urandom_range(7)), $urandom, 3'($urandom_range(7)));
   endtask

   // A well-formed exchange: clear, nonce, key, blanks, data, message, tag.
   task automatic send_session;
      int     count;
      op_type dir;
      send_beat(OP_INIT, $urandom, 3'($urandom_range(7)));
      count = $urandom_range(4);
      for (int i = 0; i < count; i++) begin
         send_beat(OP_ABSORB_UNKEYED, $urandom,
                   3'(($urandom_range(15) == 0) ? $urandom_range(7) : $urandom_range(1)));
      end
      count = $urandom_range(4);
      for (int i = 0; i < count; i++) begin
         send_beat(OP_ABSORB_KEYED, $urandom, 3'd4);
      end
      send_beat(OP_ABSORB_KEYED, $urandom, 3'($urandom_range(3)));
      count = $urandom_range(8);
      for (int i = 0; i < count; i++) begin
         send_beat(OP_BLANK, $urandom, 3'($urandom_range(7)));
      end
      count = $urandom_range(3);
      for (int i = 0; i < count; i++) begin
         send_beat(OP_ABSORB_KEYED, $urandom, 3'($urandom_range(7)));
      end
      dir = ($urandom_range(1) == 1) ? OP_ENCRYPT : OP_DECRYPT;
      count = $urandom_range(6);
      for (int i = 0; i < count; i++) begin
         send_beat(dir, $urandom, 3'(($urandom_range(3) == 0) ? $urandom_range(7) : 4));
      end
      send_beat(dir, $urandom, 3'($urandom_range(4)));
      count = $urandom_range(8);
      for (int i = 0; i < count; i++) begin
         send_beat(OP_BLANK, $urandom, 3'($urandom_range(7)));
      end
      count = $urandom_range(4);
      for (int i = 0; i < count; i++) begin
         send_beat(OP_SQUEEZE, $urandom, 3'($urandom_range(7)));
      end
   endtask

   initial begin : stimulus
      int target;
      req_chan.valid   = 1'b0;
      req_chan.op      = OP_NONE;
      req_chan.data_in = '0;
      req_chan.length  = '0;
      idle_pct  = 0;
      stall_pct = 0;
      reset = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed beats: field extremes, every operation and the corner cases.
      send_beat(OP_SQUEEZE,        32'hFFFF_FFFF, 3'd4);
      send_beat(OP_ABSORB_UNKEYED, 32'hFFFF_FFFF, 3'd0);
      send_beat(OP_ABSORB_UNKEYED, 32'hFFFF_FFFF, 3'd1);
      send_beat(OP_ABSORB_UNKEYED, 32'h1234_5678, 3'd2);
      send_beat(OP_ABSORB_UNKEYED, 32'hFFFF_FFFF, 3'd7);
      send_beat(OP_ABSORB_KEYED,   32'hFFFF_FFFF, 3'd0);
      send_beat(OP_ABSORB_KEYED,   32'hFFFF_FFFF, 3'd4);
      send_beat(OP_ABSORB_KEYED,   32'hA5A5_A5A5, 3'd7);
      send_beat(OP_ENCRYPT,        32'hFFFF_FFFF, 3'd1);
      send_beat(OP_ENCRYPT,        32'hFFFF_FFFF, 3'd2);
      send_beat(OP_ENCRYPT,        32'hFFFF_FFFF, 3'd3);
      send_beat(OP_ENCRYPT,        32'h0000_0000, 3'd4);
      send_beat(OP_ENCRYPT,        32'hDEAD_BEEF, 3'd0);
      send_beat(OP_DECRYPT,        32'hFFFF_FFFF, 3'd0);
      send_beat(OP_DECRYPT,        32'hFFFF_FFFF, 3'd4);
      send_beat(OP_DECRYPT,        32'h0F0F_0F0F, 3'd6);
      send_beat(OP_BLANK,          32'hFFFF_FFFF, 3'd7);
      send_beat(OP_SQUEEZE,        32'hFFFF_FFFF, 3'd0);
      send_beat(OP_SQUEEZE,        32'h0000_0000, 3'd2);
      send_beat(OP_SQUEEZE,        32'hFFFF_FFFF, 3'd5);
      send_beat(OP_NONE,           32'hFFFF_FFFF, 3'd7);
      send_beat(OP_INIT,           32'hFFFF_FFFF, 3'd7);
      send_beat(OP_SQUEEZE,        32'h0000_0000, 3'd4);
      drain();

      // Random phases with different amounts of idling on each side.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 61; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 61; end
            default: begin idle_pct = 29; stall_pct = 29; end
         endcase
         target = beats_sent + BeatsPerPhase;
         while (beats_sent < target) begin
            if ($urandom_range(9) < 8) begin
               send_session();
            end else begin
               repeat ($urandom_range(1, 5)) noise_beat();
            end
         end
         drain();
      end

      repeat (10) @(negedge clock);
      if (errors == 0 && outstanding == 0) begin
         $display("** sponge_duplex_cipher_257: PASSED **");
      end else begin
         $display("** sponge_duplex_cipher_257: FAILED **");
      end
      $finish;
   end

endmodule
